// ----- design/gfli_pkg.sv -----
// ----------------------------------------------------------------------------
// gfli_pkg
// Shared constants, payload types and controller/datapath handshake structs
// for the gap-fill linear interpolator.
// ----------------------------------------------------------------------------
package gfli_pkg;

   localparam int MAX_GAP      = 63;
   localparam int SAMPLE_WIDTH = 32;

   localparam int CNT_W  = $clog2(MAX_GAP + 1);
   localparam int DEN_W  = CNT_W + 1;
   localparam int DIFF_W = SAMPLE_WIDTH + 1;
   localparam int PROD_W = DIFF_W + DEN_W;
   localparam int MAG_W  = SAMPLE_WIDTH + CNT_W;
   localparam int REM_W  = DEN_W + 1;
   localparam int STEP_W = $clog2(MAG_W + 1);

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_value;
      logic                           sample_missing;
      logic                           series_end;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] out_value;
      logic                           out_missing;
      logic                           gap_overflow;
      logic                           run_last;
      logic                           series_last;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic plan;
      logic mul;
      logic div_start;
      logic div_step;
      logic emit;
      logic next;
      logic finish;
   } gfli_cmd_type;

   typedef struct packed {
      logic hold;
      logic need_div;
      logic div_done;
      logic out_free;
      logic final_j;
   } gfli_status_type;

endpackage

// ----- design/gfli_ctrl.sv -----
// ----------------------------------------------------------------------------
// gfli_ctrl
// Sequencer: accepts one transaction, then walks its results one at a time,
// running the multiply and the iterative divide for interpolated samples.
// ----------------------------------------------------------------------------
module gfli_ctrl
   import gfli_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  gfli_status_type status,
   output gfli_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_PLAN   = 6'b000010,
      ST_MUL    = 6'b000100,
      ST_DSTART = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_PUT    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            cmd.plan = 1'b1;
            if (status.hold) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.need_div) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_PUT;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_PUT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_PUT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.final_j) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  cmd.next = 1'b1;
                  state_in = ST_PLAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ----- design/gfli_datapath.sv -----
// ----------------------------------------------------------------------------
// gfli_datapath
// Series state, held transaction, k*diff multiplier, restoring divider and
// the result register.
// ----------------------------------------------------------------------------
module gfli_datapath
   import gfli_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_payload,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data,
   input  logic            rsp_stall,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload,
   input  gfli_cmd_type    cmd,
   output gfli_status_type status
);

   // series state
   logic signed [SAMPLE_WIDTH-1:0] prev_ff, prev_in;
   logic                           have_ff, have_in;
   logic [CNT_W-1:0]               pend_ff, pend_in;
   logic                           ovfm_ff, ovfm_in;
   logic                           rule_ff, rule_in;

   // current transaction and work registers
   req_payload_type                item_ff, item_in;
   logic [CNT_W-1:0]               j_ff, j_in;
   logic signed [DIFF_W-1:0]       diff_ff, diff_in;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic [MAG_W-1:0]               quo_ff, quo_in;
   logic [REM_W-1:0]               rem_ff, rem_in;
   logic                           neg_ff, neg_in;
   logic [STEP_W-1:0]              dstep_ff, dstep_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   rsp_payload_type                rsp_ff, rsp_in;

   logic                           miss;
   logic                           ovf_item;
   logic                           final_j;
   logic [CNT_W-1:0]               k;
   logic [DEN_W-1:0]               den;
   logic [REM_W-1:0]               trial;
   logic                           ge;
   logic [PROD_W-1:0]              prod_abs;
   logic signed [DIFF_W-1:0]       q_signed;
   logic signed [DIFF_W-1:0]       interp;
   rsp_payload_type                res;

   assign miss     = item_ff.sample_missing;
   assign ovf_item = miss & (ovfm_ff | (pend_ff == CNT_W'(MAX_GAP)));
   assign final_j  = (j_ff == pend_ff);
   assign k        = j_ff + CNT_W'(1);
   assign den      = {1'b0, pend_ff} + DEN_W'(1);
   assign trial    = {rem_ff[REM_W-2:0], quo_ff[MAG_W-1]};
   assign ge       = (trial >= {1'b0, den});
   assign prod_abs = prod_ff[PROD_W-1] ? (-prod_ff) : prod_ff;
   assign q_signed = neg_ff ? -$signed(quo_ff[DIFF_W-1:0]) : $signed(quo_ff[DIFF_W-1:0]);
   assign interp   = {prev_ff[SAMPLE_WIDTH-1], prev_ff} + q_signed;

   always_comb begin
      res = '0;
      if (ovf_item) begin
         res.out_missing  = 1'b1;
         res.gap_overflow = 1'b1;
      end else if (miss) begin
         res.out_missing = ~(rule_ff & have_ff);
         res.out_value   = res.out_missing ? '0 : prev_ff;
      end else if (final_j) begin
         res.out_value = item_ff.sample_value;
      end else if (have_ff) begin
         res.out_value = interp[SAMPLE_WIDTH-1:0];
      end else begin
         res.out_missing = ~rule_ff;
         res.out_value   = rule_ff ? item_ff.sample_value : '0;
      end
      res.run_last    = final_j;
      res.series_last = final_j & item_ff.series_end;
   end

   assign status.hold     = miss & ~ovf_item & ~item_ff.series_end;
   assign status.need_div = ~miss & have_ff & ~final_j;
   assign status.div_done = (dstep_ff == STEP_W'(MAG_W));
   assign status.out_free = ~rsp_valid_ff | ~rsp_stall;
   assign status.final_j  = final_j;

   always_comb begin
      prev_in      = prev_ff;
      have_in      = have_ff;
      pend_in      = pend_ff;
      ovfm_in      = ovfm_ff;
      rule_in      = csr_wr_en ? csr_wr_data : rule_ff;
      item_in      = cmd.load ? req_payload : item_ff;
      j_in         = j_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      dstep_in     = dstep_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;

      if (cmd.load) begin
         j_in = '0;
      end
      if (cmd.next) begin
         j_in = j_ff + CNT_W'(1);
      end
      if (cmd.plan) begin
         diff_in = {item_ff.sample_value[SAMPLE_WIDTH-1], item_ff.sample_value}
                 - {prev_ff[SAMPLE_WIDTH-1], prev_ff};
      end
      if (cmd.mul) begin
         prod_in = PROD_W'($signed({1'b0, k}) * diff_ff);
      end
      if (cmd.div_start) begin
         quo_in   = prod_abs[MAG_W-1:0];
         rem_in   = '0;
         neg_in   = prod_ff[PROD_W-1];
         dstep_in = '0;
      end
      if (cmd.div_step) begin
         rem_in   = ge ? (trial - {1'b0, den}) : trial;
         quo_in   = {quo_ff[MAG_W-2:0], ge};
         dstep_in = dstep_ff + STEP_W'(1);
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
      if (cmd.finish) begin
         if (item_ff.series_end) begin
            prev_in = '0;
            have_in = 1'b0;
            pend_in = '0;
            ovfm_in = 1'b0;
         end else if (~miss) begin
            prev_in = item_ff.sample_value;
            have_in = 1'b1;
            pend_in = '0;
            ovfm_in = 1'b0;
         end else if (ovfm_ff) begin
            pend_in = pend_ff;
         end else if (pend_ff == CNT_W'(MAX_GAP)) begin
            pend_in = '0;
            ovfm_in = 1'b1;
         end else begin
            pend_in = pend_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         have_ff      <= 1'b0;
         pend_ff      <= '0;
         ovfm_ff      <= 1'b0;
         rule_ff      <= 1'b0;
         j_ff         <= '0;
         dstep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         have_ff      <= have_in;
         pend_ff      <= pend_in;
         ovfm_ff      <= ovfm_in;
         rule_ff      <= rule_in;
         j_ff         <= j_in;
         dstep_ff     <= dstep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_ovfm_no_pending: assert property (@(posedge clock) disable iff (reset)
      ovfm_ff |-> (pend_ff == '0))
      else $error("overflow mode with a held run");

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (~rsp_valid_ff | ~rsp_stall))
      else $error("result register overwritten");

   a_series_end_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish & item_ff.series_end) |=> (~have_ff & ~ovfm_ff & (pend_ff == '0)))
      else $error("series state not cleared at series end");

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (dstep_ff < STEP_W'(MAG_W)))
      else $error("divider stepped past its length");

   a_interp_has_gap: assert property (@(posedge clock) disable iff (reset)
      cmd.mul |-> (have_ff & ~miss & (j_ff < pend_ff)))
      else $error("interpolation outside a bounded gap");

endmodule

// ----- design/gap_fill_linear_interpolator_top.sv -----
// ----------------------------------------------------------------------------
// gap_fill_linear_interpolator_top
// Fills bounded runs of missing Q16.16 samples by linear interpolation and
// handles leading, trailing and overlong gaps.
// ----------------------------------------------------------------------------
//  channel   signals                              direction
//  req       req_valid, req_stall, req_payload    in  (stall out)
//  rsp       rsp_valid, rsp_stall, rsp_payload    out (stall in)
//  csr       csr_wr_en, csr_wr_data (end_rule)    in
//
//  One transaction at a time; each result passes the plan and output states,
//  an interpolated one adds the multiply, divider load and divider states.
//  A held missing sample passes only the load and plan states. The restoring
//  divider sets the rate.
//  Synchronous active-high reset clears series state and end_rule.
//  rsp_stall holds the result register; the next transaction is taken while
//  the final result of the previous one still waits.
// ----------------------------------------------------------------------------
module gap_fill_linear_interpolator_top
   import gfli_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data
);

   gfli_cmd_type    cmd;
   gfli_status_type status;

   gfli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gfli_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gap-fill linear interpolator. Directed series
// cover full-scale interpolation, truncation, leading, trailing and
// all-missing gaps under both end rules. Runs at and past the gap limit
// follow, then random series with random gaps. A predictor queues the
// expected samples per accepted transaction and every result is compared
// in order. Both sides idle at random, except in one random phase.
// ----------------------------------------------------------------------------
module tb_top;
   import gfli_pkg::*;

   localparam int CYCLE_LIMIT   = 5_000_000;
   localparam int SETTLE_CYCLES = 100;
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_wr_en   = 1'b0;
   logic            csr_wr_data = 1'b0;

   logic            no_idle     = 1'b0;
   int unsigned     mismatches  = 0;
   int unsigned     cycle_count = 0;
   rsp_payload_type expected_samples[$];
   rsp_payload_type want;

   // fill model state
   logic signed [SAMPLE_WIDTH-1:0] last_good_value = '0;
   logic                           seen_good       = 1'b0;
   int                             held_count      = 0;
   logic                           overflow_run    = 1'b0;
   logic                           fill_end_gaps   = 1'b0;

   gap_fill_linear_interpolator_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(0, 99) < 37);
   end

   function automatic rsp_payload_type make_sample(input longint value, input logic miss,
                                                   input logic ovf);
      rsp_payload_type r;
      r              = '0;
      r.out_value    = miss ? '0 : value[SAMPLE_WIDTH-1:0];
      r.out_missing  = miss;
      r.gap_overflow = ovf;
      return r;
   endfunction

   function automatic void predict_filled_samples(input req_payload_type item);
      rsp_payload_type                run[$];
      logic signed [SAMPLE_WIDTH-1:0] cur;
      longint                         diff;
      longint                         den;
      int                             k;
      logic                           fill;
      run = {};
      cur = item.sample_value;
      if (!item.sample_missing) begin
         if (held_count > 0) begin
            if (seen_good) begin
               diff = longint'(cur) - longint'(last_good_value);
               den  = held_count + 1;
               for (k = 1; k <= held_count; k++)
                  run.push_back(make_sample(longint'(last_good_value) + (k * diff) / den,
                                            1'b0, 1'b0));
            end else begin
               for (k = 0; k < held_count; k++)
                  run.push_back(make_sample(longint'(cur), !fill_end_gaps, 1'b0));
            end
         end
         run.push_back(make_sample(longint'(cur), 1'b0, 1'b0));
         last_good_value = cur;
         seen_good       = 1'b1;
         held_count      = 0;
         overflow_run    = 1'b0;
      end else if (overflow_run) begin
         run.push_back(make_sample(0, 1'b1, 1'b1));
      end else if (held_count < MAX_GAP) begin
         held_count++;
         if (item.series_end) begin
            fill = fill_end_gaps && seen_good;
            for (k = 0; k < held_count; k++)
               run.push_back(make_sample(longint'(last_good_value), !fill, 1'b0));
         end
      end else begin
         for (k = 0; k <= held_count; k++)
            run.push_back(make_sample(0, 1'b1, 1'b1));
         held_count   = 0;
         overflow_run = 1'b1;
      end
      if (run.size() > 0) begin
         run[run.size()-1].run_last    = 1'b1;
         run[run.size()-1].series_last = item.series_end;
      end
      if (item.series_end) begin
         last_good_value = '0;
         seen_good       = 1'b0;
         held_count      = 0;
         overflow_run    = 1'b0;
      end
      foreach (run[i]) expected_samples.push_back(run[i]);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: val=%h miss=%b ovf=%b rl=%b sl=%b",
                        rsp_payload.out_value, rsp_payload.out_missing,
                        rsp_payload.gap_overflow, rsp_payload.run_last,
                        rsp_payload.series_last);
         end else begin
            want = expected_samples.pop_front();
            if (rsp_payload.out_value !== want.out_value ||
                rsp_payload.out_missing !== want.out_missing ||
                rsp_payload.gap_overflow !== want.gap_overflow ||
                rsp_payload.run_last !== want.run_last ||
                rsp_payload.series_last !== want.series_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp val=%h miss=%b ovf=%b rl=%b sl=%b",
                           want.out_value, want.out_missing, want.gap_overflow,
                           want.run_last, want.series_last,
                           " / got val=%h miss=%b ovf=%b rl=%b sl=%b",
                           rsp_payload.out_value, rsp_payload.out_missing,
                           rsp_payload.gap_overflow, rsp_payload.run_last,
                           rsp_payload.series_last);
            end
         end
      end
   end

   function automatic req_payload_type sample_item(input logic signed [SAMPLE_WIDTH-1:0] value,
                                                   input logic missing, input logic last);
      req_payload_type item;
      item.sample_value   = value;
      item.sample_missing = missing;
      item.series_end     = last;
      return item;
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] any_sample();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MIN;
         1: return SAMPLE_MAX;
         2: return '0;
         3: return {{(SAMPLE_WIDTH-20){r[19]}}, r[19:0]};
         default: return r;
      endcase
   endfunction

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 4);
      if (r < 93) return $urandom_range(5, 20);
      if (r < 97) return $urandom_range(21, MAX_GAP);
      return $urandom_range(MAX_GAP + 1, MAX_GAP + 7);
   endfunction

   task automatic send_item(input req_payload_type item);
      while (!no_idle && $urandom_range(0, 99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_filled_samples(item);
   endtask

   task automatic send_gap(input int len);
      for (int i = 0; i < len; i++) send_item(sample_item($urandom(), 1'b1, 1'b0));
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_end_rule(input logic rule);
      settle_block();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= rule;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      fill_end_gaps  = rule;
   endtask

   task automatic test_interpolation();
      set_end_rule(1'b0);
      send_item(sample_item(SAMPLE_MIN, 1'b0, 1'b0));
      send_gap(2);
      send_item(sample_item(SAMPLE_MAX, 1'b0, 1'b0));
      send_item(sample_item('1, 1'b1, 1'b0));
      send_item(sample_item('0, 1'b1, 1'b0));
      send_item(sample_item(32'h5555_5555, 1'b1, 1'b0));
      send_item(sample_item(SAMPLE_MIN, 1'b0, 1'b1));
      // negative step, quotient truncates toward zero
      send_item(sample_item(32'sd7, 1'b0, 1'b0));
      send_gap(2);
      send_item(sample_item(-32'sd1, 1'b0, 1'b1));
      send_item(sample_item('0, 1'b0, 1'b1));
   endtask

   task automatic test_end_gaps();
      for (int rule = 0; rule < 2; rule++) begin
         set_end_rule(rule[0]);
         send_gap(2);
         send_item(sample_item(32'sh0001_8000, 1'b0, 1'b0));
         send_gap(1);
         send_item(sample_item(32'h0, 1'b1, 1'b1));
         // all-missing series
         send_gap(1);
         send_item(sample_item('1, 1'b1, 1'b1));
      end
   endtask

   task automatic test_long_gaps();
      set_end_rule(1'b1);
      send_item(sample_item(any_sample(), 1'b0, 1'b0));
      send_gap(MAX_GAP);
      send_item(sample_item(any_sample(), 1'b0, 1'b0));
      // overlong run, one sample in overflow mode, then a good end
      send_gap(MAX_GAP + 2);
      send_item(sample_item(any_sample(), 1'b0, 1'b1));
   endtask

   task automatic send_random_series(output int count);
      req_payload_type series[$];
      int              segments;
      series   = {};
      segments = $urandom_range(1, 5);
      for (int s = 0; s < segments; s++) begin
         for (int i = gap_length(); i > 0; i--)
            series.push_back(sample_item($urandom(), 1'b1, 1'b0));
         if ($urandom_range(0, 9) != 0)
            series.push_back(sample_item(any_sample(), 1'b0, 1'b0));
      end
      if ($urandom_range(0, 1))
         for (int i = gap_length(); i > 0; i--)
            series.push_back(sample_item($urandom(), 1'b1, 1'b0));
      if (series.size() == 0) series.push_back(sample_item($urandom(), 1'b1, 1'b0));
      series[series.size()-1].series_end = 1'b1;
      foreach (series[i]) send_item(series[i]);
      count = series.size();
   endtask

   task automatic test_random_series();
      int sent;
      int count;
      for (int phase = 0; phase < 4; phase++) begin
         set_end_rule(phase == 0 ? 1'b1 : phase == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
         no_idle <= (phase == 2);
         sent = 0;
         while (sent < 10) begin
            send_random_series(count);
            sent += count;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_interpolation();
      test_end_gaps();
      test_long_gaps();
      test_random_series();
      settle_block();
      if (mismatches == 0 && expected_samples.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

endmodule
